>>> design/npcm_pkg.sv
package npcm_pkg;

  localparam int PALETTE_DEPTH_DEF = 16;

  localparam int SIZE_W  = 5;
  localparam int INDEX_W = 4;
  localparam int CHAN_W  = 8;
  localparam int DIST_W  = 18;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_MATCH = 1'b1;

  typedef struct packed {
    logic wr;
    logic load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic done;
  } sts_t;

endpackage

>>> design/npcm_item_if.sv
interface npcm_item_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [npcm_pkg::INDEX_W-1:0] entry_index;
  logic [npcm_pkg::CHAN_W-1:0]  red;
  logic [npcm_pkg::CHAN_W-1:0]  green;
  logic [npcm_pkg::CHAN_W-1:0]  blue;
  logic                        end_of_batch;

  modport source (
    output valid, operation, entry_index, red, green, blue, end_of_batch,
    input  ready
  );
  modport sink (
    input  valid, operation, entry_index, red, green, blue, end_of_batch,
    output ready
  );
endinterface

>>> design/npcm_result_if.sv
interface npcm_result_if;
  logic                        valid;
  logic                        ready;
  logic [npcm_pkg::INDEX_W-1:0] nearest_index;
  logic                        batch_done;

  modport source (
    output valid, nearest_index, batch_done,
    input  ready
  );
  modport sink (
    input  valid, nearest_index, batch_done,
    output ready
  );
endinterface

>>> design/npcm_cfg_if.sv
interface npcm_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [npcm_pkg::SIZE_W-1:0] data;

  modport source (
    output valid, data,
    input  ready
  );
  modport sink (
    input  valid, data,
    output ready
  );
endinterface

>>> design/npcm_ctrl.sv
module npcm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_op,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output npcm_pkg::cmd_t cmd,
  input  npcm_pkg::sts_t sts
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       accept;
  logic       slot_free;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        if (accept && in_op == npcm_pkg::OP_WRITE) begin
          cmd.wr = 1'b1;
        end else if (accept) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.done && slot_free) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end else if (sts.done) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> design/npcm_datapath.sv
module npcm_datapath #(
  parameter int PALETTE_DEPTH = npcm_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  npcm_pkg::cmd_t               cmd,
  output npcm_pkg::sts_t               sts,
  input  logic                         cfg_we,
  input  logic [npcm_pkg::SIZE_W-1:0]  cfg_data,
  input  logic [npcm_pkg::INDEX_W-1:0] entry_index,
  input  logic [npcm_pkg::CHAN_W-1:0]  red,
  input  logic [npcm_pkg::CHAN_W-1:0]  green,
  input  logic [npcm_pkg::CHAN_W-1:0]  blue,
  input  logic                         end_of_batch,
  output logic [npcm_pkg::INDEX_W-1:0] nearest_index,
  output logic                         batch_done
);

  localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(PALETTE_DEPTH + 1);
  localparam int CW     = npcm_pkg::CHAN_W;
  localparam int DW     = npcm_pkg::DIST_W;

  logic [3*CW-1:0] mem [PALETTE_DEPTH];

  logic [npcm_pkg::SIZE_W-1:0] palette_size;
  logic [CW-1:0]               q_red;
  logic [CW-1:0]               q_green;
  logic [CW-1:0]               q_blue;
  logic                        q_eob;

  logic [CNT_W-1:0]  n_last;
  logic [CNT_W-1:0]  n_last_next;
  logic [CNT_W-1:0]  rd_cnt;
  logic              issuing;

  logic              s1_valid;
  logic              s1_last;
  logic [ADDR_W-1:0] s1_idx;
  logic [3*CW-1:0]   s1_data;

  logic              s2_valid;
  logic              s2_last;
  logic [ADDR_W-1:0] s2_idx;
  logic [DW-1:0]     s2_dist;
  logic [DW-1:0]     dist_next;

  logic [DW-1:0]     best_dist;
  logic [ADDR_W-1:0] best_idx;
  logic              done;

  function automatic logic [2*CW-1:0] sq_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return (2*CW)'(d) * (2*CW)'(d);
  endfunction

  always_comb begin
    if (palette_size == '0) begin
      n_last_next = '0;
    end else if (32'(palette_size) > PALETTE_DEPTH) begin
      n_last_next = CNT_W'(PALETTE_DEPTH - 1);
    end else begin
      n_last_next = CNT_W'(palette_size) - CNT_W'(1);
    end
  end

  assign dist_next = DW'(sq_diff(s1_data[3*CW-1:2*CW], q_red))
                   + DW'(sq_diff(s1_data[2*CW-1:CW], q_green))
                   + DW'(sq_diff(s1_data[CW-1:0], q_blue));

  always_ff @(posedge clk) begin
    if (cmd.wr && 32'(entry_index) < PALETTE_DEPTH) begin
      mem[ADDR_W'(entry_index)] <= {red, green, blue};
    end
    s1_data <= mem[rd_cnt[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_size <= npcm_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      palette_size <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_red   <= red;
      q_green <= green;
      q_blue  <= blue;
      q_eob   <= end_of_batch;
      n_last  <= n_last_next;
    end
    s1_idx  <= rd_cnt[ADDR_W-1:0];
    s1_last <= (rd_cnt == n_last);
    s2_idx  <= s1_idx;
    s2_last <= s1_last;
    s2_dist <= dist_next;
    if (s2_valid && (s2_idx == '0 || s2_dist < best_dist)) begin
      best_dist <= s2_dist;
      best_idx  <= s2_idx;
    end
    if (cmd.emit) begin
      nearest_index <= npcm_pkg::INDEX_W'(best_idx);
      batch_done    <= q_eob;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing  <= 1'b0;
      rd_cnt   <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      if (cmd.load) begin
        issuing <= 1'b1;
        rd_cnt  <= '0;
      end else if (issuing) begin
        rd_cnt <= rd_cnt + CNT_W'(1);
        if (rd_cnt == n_last) begin
          issuing <= 1'b0;
        end
      end
      s1_valid <= issuing && !cmd.load;
      s2_valid <= s1_valid;
      done     <= s2_valid && s2_last;
    end
  end

  assign sts.done = done;

endmodule

>>> design/nearest_palette_colour_match.sv
// Channel   Dir  Payload                                            Request
// item      in   operation, entry_index, red, green, blue, end_of_batch  write or match
// result    out  nearest_index, batch_done                          one per match
// cfg       in   data (palette_size)                                register write
//
// A write request is written into the palette in the cycle it is taken. A match
// scans min(max(palette_size,1),PALETTE_DEPTH) palette entries, one per cycle,
// through the single palette read port; the next request is taken only once
// the result has gone into the result register.
// The result register lets the next request enter while a result waits;
// a finished scan holds only if the previous result is still not taken.
// rst is synchronous; palette_size resets to 16, palette contents do not reset.
module nearest_palette_colour_match #(
  parameter int PALETTE_DEPTH = npcm_pkg::PALETTE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  npcm_item_if.sink     item,
  npcm_result_if.source result,
  npcm_cfg_if.sink      cfg
);

  npcm_pkg::cmd_t cmd;
  npcm_pkg::sts_t sts;

  assign cfg.ready = 1'b1;

  npcm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_op     (item.operation),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  npcm_datapath #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg.valid),
    .cfg_data      (cfg.data),
    .entry_index   (item.entry_index),
    .red           (item.red),
    .green         (item.green),
    .blue          (item.blue),
    .end_of_batch  (item.end_of_batch),
    .nearest_index (result.nearest_index),
    .batch_done    (result.batch_done)
  );

endmodule

>>> bench/nearest_palette_colour_match_tb.sv
`timescale 1ns / 100ps

module nearest_palette_colour_match_tb;

  localparam int DEPTH       = npcm_pkg::PALETTE_DEPTH_DEF;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 100;
  localparam int SETTLE      = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 150;

  typedef struct packed {
    logic [npcm_pkg::INDEX_W-1:0] nearest;
    logic                         done;
  } match_exp_t;

  typedef struct packed {
    logic                         op;
    logic [npcm_pkg::INDEX_W-1:0] idx;
    logic [23:0]                  rgb;
    logic                         eob;
    logic                         typed;
    logic [npcm_pkg::INDEX_W-1:0] nearest;
  } dir_row_t;

  logic clk;
  logic rst;

  npcm_item_if   item_ch ();
  npcm_result_if res_ch ();
  npcm_cfg_if    cfg_ch ();

  nearest_palette_colour_match u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  logic [23:0]                 palette_copy [DEPTH];
  logic [npcm_pkg::SIZE_W-1:0] search_size;
  match_exp_t                  match_q [$];
  dir_row_t                    dir_tab [$];
  int                          mismatches;
  int                          results_taken;
  int                          burst_left;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [npcm_pkg::INDEX_W-1:0] nearest_entry(input logic [23:0] q);
    int n, best, best_d, d, dr, dg, db;
    n = (search_size == 0) ? 1 : (search_size > DEPTH) ? DEPTH : int'(search_size);
    best = 0;
    best_d = -1;
    for (int i = 0; i < n; i++) begin
      dr = int'(palette_copy[i][23:16]) - int'(q[23:16]);
      dg = int'(palette_copy[i][15:8]) - int'(q[15:8]);
      db = int'(palette_copy[i][7:0]) - int'(q[7:0]);
      d = dr * dr + dg * dg + db * db;
      if (best_d < 0 || d < best_d) begin
        best_d = d;
        best = i;
      end
    end
    return best[npcm_pkg::INDEX_W-1:0];
  endfunction

  // update the palette copy or queue the predicted match for an accepted request
  function automatic void track_request(input logic op,
                                        input logic [npcm_pkg::INDEX_W-1:0] idx,
                                        input logic [23:0] rgb, input logic eob);
    match_exp_t e;
    if (op == npcm_pkg::OP_WRITE) begin
      if (int'(idx) < DEPTH) palette_copy[idx] = rgb;
    end else begin
      e.nearest = nearest_entry(rgb);
      e.done = eob;
      match_q.push_back(e);
    end
  endfunction

  function automatic dir_row_t mk_row(input logic op, input int idx, input logic [23:0] rgb,
                                      input int eob, input int typed, input int nearest);
    dir_row_t r;
    r.op = op;
    r.idx = idx[npcm_pkg::INDEX_W-1:0];
    r.rgb = rgb;
    r.eob = eob[0];
    r.typed = typed[0];
    r.nearest = nearest[npcm_pkg::INDEX_W-1:0];
    return r;
  endfunction

  function automatic logic [7:0] nudge(input logic [7:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 12)) - 6;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic logic [23:0] pick_query();
    logic [23:0] base;
    base = palette_copy[$urandom_range(0, DEPTH - 1)];
    case ($urandom_range(0, 4))
      0: return base;
      1: return {nudge(base[23:16]), nudge(base[15:8]), nudge(base[7:0])};
      2: return {{8{$urandom_range(0, 1) == 1}}, {8{$urandom_range(0, 1) == 1}},
                 {8{$urandom_range(0, 1) == 1}}};
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_colour();
    case ($urandom_range(0, 3))
      // duplicate colors make ties
      0: return palette_copy[$urandom_range(0, DEPTH - 1)];
      1: return {{8{$urandom_range(0, 1) == 1}}, {8{$urandom_range(0, 1) == 1}},
                 {8{$urandom_range(0, 1) == 1}}};
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [npcm_pkg::SIZE_W-1:0] plan_size(input int p);
    case (p)
      0: return 5'd1;
      1: return 5'd0;
      2: return 5'd31;
      3: return 5'd16;
      4: return 5'd17;
      5: return 5'd2;
      default: return 5'($urandom_range(3, 15));
    endcase
  endfunction

  task automatic offer_request(input logic op, input logic [npcm_pkg::INDEX_W-1:0] idx,
                               input logic [23:0] rgb, input logic eob);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_ch.valid        <= 1'b1;
    item_ch.operation    <= op;
    item_ch.entry_index  <= idx;
    item_ch.red          <= rgb[23:16];
    item_ch.green        <= rgb[15:8];
    item_ch.blue         <= rgb[7:0];
    item_ch.end_of_batch <= eob;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task automatic drain_and_resize(input logic [npcm_pkg::SIZE_W-1:0] sz);
    while (match_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= sz;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    search_size = sz;
  endtask

  // receiver: random stall patterns, one long hold-off to back up the input
  initial begin : result_sink
    int mode, mode_left;
    bit held;
    mode = 0;
    mode_left = 0;
    held = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && results_taken >= HOLD_AFTER) begin
        held = 1;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        case (mode)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= ($urandom_range(0, 3) != 0);
          default: res_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    match_exp_t e;
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_taken++;
      if (match_q.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result with none expected: index %0d done %0b", $time,
                   res_ch.nearest_index, res_ch.batch_done);
        mismatches++;
      end else begin
        e = match_q.pop_front();
        if (res_ch.nearest_index !== e.nearest || res_ch.batch_done !== e.done) begin
          if (mismatches < 10)
            $display("%0t: expected index %0d done %0b, got index %0d done %0b", $time,
                     e.nearest, e.done, res_ch.nearest_index, res_ch.batch_done);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t row;
    match_exp_t e;
    logic op;
    logic [23:0] rgb;

    mismatches = 0;
    results_taken = 0;
    burst_left = 0;
    search_size = npcm_pkg::SIZE_RESET;
    for (int i = 0; i < DEPTH; i++) palette_copy[i] = '0;

    rst <= 1'b1;
    item_ch.valid        <= 1'b0;
    item_ch.operation    <= npcm_pkg::OP_WRITE;
    item_ch.entry_index  <= '0;
    item_ch.red          <= '0;
    item_ch.green        <= '0;
    item_ch.blue         <= '0;
    item_ch.end_of_batch <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;

    // full palette first, so no match ever reads an unwritten entry
    dir_tab.push_back(mk_row(npcm_pkg::OP_WRITE, 0, 24'h000000, 0, 0, 0));
    dir_tab.push_back(mk_row(npcm_pkg::OP_WRITE, 1, 24'hFFFFFF, 0, 0, 0));
    dir_tab.push_back(mk_row(npcm_pkg::OP_WRITE, 2, 24'hFF0000, 0, 0, 0));
    dir_tab.push_back(mk_row(npcm_pkg::OP_WRITE, 3, 24'h00FF00, 0, 0, 0));
    dir_tab.push_back(mk_row(npcm_pkg::OP_WRITE, 4, 24'h0000FF, 0, 0, 0));
    dir_tab.push_back(mk_row(npcm_pkg::OP_WRITE, 5, 24'hFFFFFF, 0, 0, 0));
    dir_tab.push_back(mk_row(npcm_pkg::OP_WRITE, 6, 24'h808080, 0, 0, 0));
    dir_tab.push_back(mk_row(npcm_pkg::OP_WRITE, 7, 24'h404040, 0, 0, 0));
    dir_tab.push_back(mk_row(npcm_pkg::OP_WRITE, 8, 24'hC0C0C0, 0, 0, 0));
    dir_tab.push_back(mk_row(npcm_pkg::OP_WRITE, 9, 24'h123456, 0, 0, 0));
    dir_tab.push_back(mk_row(npcm_pkg::OP_WRITE, 10, 24'hA5A5A5, 0, 0, 0));
    dir_tab.push_back(mk_row(npcm_pkg::OP_WRITE, 11, 24'h5A5A5A, 0, 0, 0));
    dir_tab.push_back(mk_row(npcm_pkg::OP_WRITE, 12, 24'hFFFF00, 0, 0, 0));
    dir_tab.push_back(mk_row(npcm_pkg::OP_WRITE, 13, 24'h00FFFF, 0, 0, 0));
    dir_tab.push_back(mk_row(npcm_pkg::OP_WRITE, 14, 24'hFF00FF, 0, 0, 0));
    dir_tab.push_back(mk_row(npcm_pkg::OP_WRITE, 15, 24'h010101, 1, 0, 0));
    dir_tab.push_back(mk_row(npcm_pkg::OP_MATCH, 15, 24'h000000, 1, 1, 0));
    // tie between entries 1 and 5: lowest index
    dir_tab.push_back(mk_row(npcm_pkg::OP_MATCH, 0, 24'hFFFFFF, 0, 1, 1));
    dir_tab.push_back(mk_row(npcm_pkg::OP_MATCH, 7, 24'hFF0000, 0, 1, 2));
    dir_tab.push_back(mk_row(npcm_pkg::OP_MATCH, 0, 24'h00FF00, 1, 1, 3));
    dir_tab.push_back(mk_row(npcm_pkg::OP_MATCH, 15, 24'h0000FF, 1, 1, 4));
    dir_tab.push_back(mk_row(npcm_pkg::OP_MATCH, 3, 24'hFF00FF, 0, 1, 14));
    dir_tab.push_back(mk_row(npcm_pkg::OP_MATCH, 9, 24'h7F7F7F, 0, 0, 0));
    dir_tab.push_back(mk_row(npcm_pkg::OP_MATCH, 0, 24'h020202, 1, 0, 0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      offer_request(row.op, row.idx, row.rgb, row.eob);
      if (row.op == npcm_pkg::OP_MATCH && row.typed) begin
        e.nearest = row.nearest;
        e.done = row.eob;
        match_q.push_back(e);
      end else begin
        track_request(row.op, row.idx, row.rgb, row.eob);
      end
    end
    item_ch.valid <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      drain_and_resize(plan_size(p));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        op = ($urandom_range(0, 9) < 3) ? npcm_pkg::OP_WRITE : npcm_pkg::OP_MATCH;
        rgb = (op == npcm_pkg::OP_WRITE) ? pick_colour() : pick_query();
        e.nearest = npcm_pkg::INDEX_W'($urandom_range(0, DEPTH - 1));
        e.done = ($urandom_range(0, 3) == 0);
        offer_request(op, e.nearest, rgb, e.done);
        track_request(op, e.nearest, rgb, e.done);
      end
      item_ch.valid <= 1'b0;
    end

    while (match_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    mismatches += match_q.size();
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
